// ===== hdl/relay_member_table_fanout_unit_macros.svh =====
// Assertion macros for the relay member table.
`ifndef RELAY_MEMBER_TABLE_FANOUT_UNIT_MACROS_SVH
`define RELAY_MEMBER_TABLE_FANOUT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RMTF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmtf: assertion failed");
`define RMTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmtf: assertion failed");
`else
`define RMTF_ASSERT_SAME(label, ante, cons)
`define RMTF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/rmtf_pkg.sv =====
`default_nettype none
package rmtf_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_FWD  = 2'd0;
  localparam status_t ST_LONE = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_TICK = 2'd3;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd180;

  // one table row; valid bits live in flops outside the memory
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/rmtf_in_if.sv =====
`default_nettype none
interface rmtf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] src_ip;
  logic [15:0] src_port;

  modport source (output valid, output command, output src_ip, output src_port,
                  input ready);
  modport sink   (input valid, input command, input src_ip, input src_port,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/rmtf_out_if.sv =====
`default_nettype none
interface rmtf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [3:0]  dest_slot;
  logic [3:0]  sender_slot;
  logic [4:0]  active_count;
  logic        last;

  modport source (output valid, output status, output dest_ip, output dest_port,
                  output dest_slot, output sender_slot, output active_count,
                  output last, input ready);
  modport sink   (input valid, input status, input dest_ip, input dest_port,
                  input dest_slot, input sender_slot, input active_count,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/rmtf_cfg_if.sv =====
`default_nettype none
interface rmtf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink   (input valid, input timeout_ticks, output ready);
endinterface
`default_nettype wire

// ===== hdl/relay_member_table_fanout_unit.sv =====
// Relay member table with fan-out.
// in_ch takes one item: a packet from (src_ip, src_port) or a time tick.
// out_ch gives the results: one per other valid member (status forward),
// or a single lone-member, table-full or tick-done result; last marks the
// final result of an item. cfg_ch writes timeout_ticks; it is always ready.
// One compare/age unit walks the table memory, one slot per cycle.
// A tick, a rejected packet or a lone member is handled by the table walk
// alone; a forwarded packet adds the fan-out walk after the lookup walk,
// over the same memory port.
// in_ch is ready only between items, so one item is in work at a time.
// A result sits in the output register until taken; while out_ch stalls
// the fan-out walk holds its slot. The next item may be accepted while the
// final result still waits.
// Reset clears all valid bits, the tick counter and the sequencer, and sets
// timeout_ticks to 180. Table memory is not cleared: valid bits gate it.
`default_nettype none
module relay_member_table_fanout_unit #(
  parameter int MEMBER_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rmtf_in_if.sink    in_ch,
  rmtf_out_if.source out_ch,
  rmtf_cfg_if.sink   cfg_ch
);
  import rmtf_pkg::*;

  `include "relay_member_table_fanout_unit_macros.svh"

  localparam int SLOT_W = $clog2(MEMBER_SLOTS);
  localparam int CNT_W  = $clog2(MEMBER_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MEMBER_SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN0  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FAN0   = 3'd4;
  localparam logic [2:0] S_FAN    = 3'd5;
  localparam logic [2:0] S_EMIT1  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic                    cmd_r, cmd_nxt;
  logic [31:0]             ip_r, ip_nxt;
  logic [15:0]             port_r, port_nxt;
  logic [31:0]             now_r, now_nxt;
  logic [15:0]             timeout_r;
  logic [MEMBER_SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic                    match_v_r, match_v_nxt;
  logic [SLOT_W-1:0]       match_idx_r, match_idx_nxt;
  logic                    free_v_r, free_v_nxt;
  logic [SLOT_W-1:0]       free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        sent_r, sent_nxt;
  logic [SLOT_W-1:0]       sender_r, sender_nxt;
  status_t                 st_r, st_nxt;

  entry_t                  mem [MEMBER_SLOTS];
  entry_t                  rd_q_r;
  logic [SLOT_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  entry_t                  wr_data;

  logic                    out_valid_r;
  status_t                 out_status_r, ol_status;
  logic [31:0]             out_ip_r, ol_ip;
  logic [15:0]             out_port_r, ol_port;
  logic [3:0]              out_dslot_r, ol_dslot;
  logic [3:0]              out_sslot_r, ol_sslot;
  logic [4:0]              out_cnt_r;
  logic                    out_last_r, ol_last;
  logic                    out_load;
  logic                    out_free;

  logic                    in_fire;
  logic                    idx_last;
  logic [SLOT_W-1:0]       idx_inc;
  logic                    cur_v;
  logic [31:0]             age;
  logic                    expire;
  logic                    hit;
  logic                    is_dest;
  logic                    fan_last;
  logic [SLOT_W+3:0]       idx_ext;
  logic [SLOT_W+3:0]       sender_ext;
  logic [CNT_W+4:0]        cnt_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign idx_last = (idx_r == LAST_SLOT);
  assign idx_inc  = idx_last ? '0 : idx_r + SLOT_W'(1);
  assign cur_v    = valid_r[idx_r];
  assign age      = now_r - rd_q_r.seen;
  assign expire   = cur_v && (age > {16'd0, timeout_r});
  assign hit      = cur_v && (rd_q_r.ip == ip_r) && (rd_q_r.port == port_r);
  assign is_dest  = cur_v && (idx_r != sender_r);
  // last destination once sent + 1 reaches the other-member count
  assign fan_last = ({1'b0, sent_r} + (CNT_W+1)'(2)) == {1'b0, cnt_r};
  assign out_free = !out_valid_r || out_ch.ready;

  // slot numbers and counts are truncated to the field widths
  assign idx_ext    = {4'd0, idx_r};
  assign sender_ext = {4'd0, sender_r};
  assign cnt_ext    = {5'd0, cnt_r};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ip_nxt        = ip_r;
    port_nxt      = port_r;
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    match_v_nxt   = match_v_r;
    match_idx_nxt = match_idx_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    cnt_nxt       = cnt_r;
    sent_nxt      = sent_r;
    sender_nxt    = sender_r;
    st_nxt        = st_r;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = sender_r;
    wr_data       = '{ip: ip_r, port: port_r, seen: now_r};
    out_load      = 1'b0;
    ol_status     = ST_FWD;
    ol_ip         = 32'd0;
    ol_port       = 16'd0;
    ol_dslot      = 4'd0;
    ol_sslot      = 4'd0;
    ol_last       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_ch.command;
          ip_nxt   = in_ch.src_ip;
          port_nxt = in_ch.src_port;
          if (in_ch.command == CMD_TICK) begin
            now_nxt = now_r + 32'd1;
          end
          state_nxt = S_SCAN0;
        end
      end
      S_SCAN0: begin
        rd_addr     = '0;
        idx_nxt     = '0;
        match_v_nxt = 1'b0;
        free_v_nxt  = 1'b0;
        cnt_nxt     = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = idx_inc;
        idx_nxt = idx_inc;
        if (cmd_r == CMD_TICK) begin
          if (expire) begin
            valid_nxt[idx_r] = 1'b0;
          end else if (cur_v) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          if (cur_v) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (hit && !match_v_r) begin
            match_v_nxt   = 1'b1;
            match_idx_nxt = idx_r;
          end
          if (!cur_v && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = idx_r;
          end
        end
        if (idx_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        sent_nxt = '0;
        if (cmd_r == CMD_TICK) begin
          st_nxt     = ST_TICK;
          sender_nxt = '0;
          state_nxt  = S_EMIT1;
        end else if (match_v_r) begin
          sender_nxt = match_idx_r;
          wr_en      = 1'b1;
          wr_addr    = match_idx_r;
          st_nxt     = ST_LONE;
          state_nxt  = (cnt_r == CNT_W'(1)) ? S_EMIT1 : S_FAN0;
        end else if (free_v_r) begin
          sender_nxt            = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          wr_en                 = 1'b1;
          wr_addr               = free_idx_r;
          cnt_nxt               = cnt_r + CNT_W'(1);
          st_nxt                = ST_LONE;
          state_nxt             = (cnt_r == '0) ? S_EMIT1 : S_FAN0;
        end else begin
          st_nxt     = ST_FULL;
          sender_nxt = '0;
          state_nxt  = S_EMIT1;
        end
      end
      S_FAN0: begin
        rd_addr   = '0;
        idx_nxt   = '0;
        state_nxt = S_FAN;
      end
      S_FAN: begin
        if (!is_dest || out_free) begin
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
          if (idx_last) begin
            state_nxt = S_IDLE;
          end
        end
        if (is_dest && out_free) begin
          out_load  = 1'b1;
          ol_status = ST_FWD;
          ol_ip     = rd_q_r.ip;
          ol_port   = rd_q_r.port;
          ol_dslot  = idx_ext[3:0];
          ol_sslot  = sender_ext[3:0];
          ol_last   = fan_last;
          sent_nxt  = sent_r + CNT_W'(1);
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          out_load  = 1'b1;
          ol_status = st_r;
          ol_sslot  = sender_ext[3:0];
          ol_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= 32'd0;
      timeout_r   <= TIMEOUT_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      valid_r <= valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        timeout_r <= cfg_ch.timeout_ticks;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ip_r        <= ip_nxt;
    port_r      <= port_nxt;
    idx_r       <= idx_nxt;
    match_v_r   <= match_v_nxt;
    match_idx_r <= match_idx_nxt;
    free_v_r    <= free_v_nxt;
    free_idx_r  <= free_idx_nxt;
    cnt_r       <= cnt_nxt;
    sent_r      <= sent_nxt;
    sender_r    <= sender_nxt;
    st_r        <= st_nxt;
    if (out_load) begin
      out_status_r <= ol_status;
      out_ip_r     <= ol_ip;
      out_port_r   <= ol_port;
      out_dslot_r  <= ol_dslot;
      out_sslot_r  <= ol_sslot;
      out_cnt_r    <= cnt_ext[4:0];
      out_last_r   <= ol_last;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.dest_ip      = out_ip_r;
  assign out_ch.dest_port    = out_port_r;
  assign out_ch.dest_slot    = out_dslot_r;
  assign out_ch.sender_slot  = out_sslot_r;
  assign out_ch.active_count = out_cnt_r;
  assign out_ch.last         = out_last_r;

  `RMTF_ASSERT_NEXT(a_tick_advances, in_fire && (in_ch.command == CMD_TICK), now_r == $past(now_r) + 32'd1)
  `RMTF_ASSERT_SAME(a_no_load_idle, state_r == S_IDLE, !out_load)
  `RMTF_ASSERT_NEXT(a_fan_keeps_valid, state_r == S_FAN, valid_r == $past(valid_r))

endmodule
`default_nettype wire

// ===== tb/rmtf_fanout_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module rmtf_fanout_checker (
  input  logic       clk,
  input  logic       rst_n,
  rmtf_in_if         in_ch,
  rmtf_out_if        out_ch,
  rmtf_cfg_if        cfg_ch,
  output int         mismatch_count,
  output int         pending_count
);
  import rmtf_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    status_t     status;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [3:0]  dest_slot;
    logic [3:0]  sender_slot;
    logic [4:0]  active_count;
    logic        last;
  } fanout_result_t;

  fanout_result_t expected_fanout[$];

  // shadow of the member table
  logic [SLOTS-1:0] slot_live;
  logic [31:0]      slot_addr  [SLOTS];
  logic [15:0]      slot_udp   [SLOTS];
  logic [31:0]      slot_stamp [SLOTS];
  logic [31:0]      clock_now;
  logic [15:0]      age_limit;

  task automatic push_result(input status_t st, input int dslot, input int sslot,
                             input logic last);
    fanout_result_t r;
    r = '0;
    r.status       = st;
    if (st == ST_FWD) begin
      r.dest_ip   = slot_addr[dslot];
      r.dest_port = slot_udp[dslot];
      r.dest_slot = dslot[3:0];
    end
    r.sender_slot  = sslot[3:0];
    r.active_count = 5'($countones(slot_live));
    r.last         = last;
    expected_fanout.push_back(r);
  endtask

  task automatic predict_fanout(input logic cmd, input logic [31:0] ip,
                                input logic [15:0] port);
    int          sender;
    int          others;
    int          k;
    logic [31:0] age;
    sender = -1;
    k      = 0;
    if (cmd == CMD_TICK) begin
      clock_now = clock_now + 32'd1;
      for (int i = 0; i < SLOTS; i++) begin
        age = clock_now - slot_stamp[i];
        if (slot_live[i] && age > {16'h0000, age_limit})
          slot_live[i] = 1'b0;
      end
      push_result(ST_TICK, 0, 0, 1'b1);
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (sender < 0 && slot_live[i] && slot_addr[i] == ip && slot_udp[i] == port)
          sender = i;
      end
      if (sender < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sender < 0 && !slot_live[i]) begin
            sender       = i;
            slot_live[i] = 1'b1;
            slot_addr[i] = ip;
            slot_udp[i]  = port;
          end
        end
      end
      if (sender < 0) begin
        push_result(ST_FULL, 0, 0, 1'b0 | 1'b1);
      end else begin
        slot_stamp[sender] = clock_now;
        others = $countones(slot_live) - 1;
        if (others == 0) begin
          push_result(ST_LONE, 0, sender, 1'b1);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && i != sender) begin
              push_result(ST_FWD, i, sender, k == others - 1);
              k++;
            end
          end
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    fanout_result_t want;
    if (expected_fanout.size() == 0) begin
      $error("result with nothing expected: status %0d", out_ch.status);
      mismatch_count++;
    end else begin
      want = expected_fanout.pop_front();
      compare_field("status",       32'(want.status),       32'(out_ch.status));
      compare_field("dest_ip",      want.dest_ip,           out_ch.dest_ip);
      compare_field("dest_port",    32'(want.dest_port),    32'(out_ch.dest_port));
      compare_field("dest_slot",    32'(want.dest_slot),    32'(out_ch.dest_slot));
      compare_field("sender_slot",  32'(want.sender_slot),  32'(out_ch.sender_slot));
      compare_field("active_count", 32'(want.active_count), 32'(out_ch.active_count));
      compare_field("last",         32'(want.last),         32'(out_ch.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_live      = '0;
      clock_now      = '0;
      age_limit      = TIMEOUT_RESET;
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_addr[i]  = '0;
        slot_udp[i]   = '0;
        slot_stamp[i] = '0;
      end
      expected_fanout.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        age_limit = cfg_ch.timeout_ticks;
      // a result taken on the same edge always belongs to an earlier item
      if (out_ch.valid && out_ch.ready)
        check_result();
      if (in_ch.valid && in_ch.ready)
        predict_fanout(in_ch.command, in_ch.src_ip, in_ch.src_port);
    end
    pending_count = expected_fanout.size();
  end

endmodule
`default_nettype wire

// ===== tb/tb_relay_member_table_fanout_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_relay_member_table_fanout_unit;
  import rmtf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 48;
  localparam int POOL_SIZE    = 24;
  localparam int PHASE_ITEMS  = 29;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   cycle_count = 0;

  logic [31:0] pool_ip   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [15:0] phase_timeout [5];

  rmtf_in_if  in_ch ();
  rmtf_out_if out_ch ();
  rmtf_cfg_if cfg_ch ();

  relay_member_table_fanout_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rmtf_fanout_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6)
      return 0;
    if ($urandom_range(0, 9) != 0)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic cmd, input logic [31:0] ip,
                           input logic [15:0] port);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.command  = cmd;
    in_ch.src_ip   = ip;
    in_ch.src_port = port;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, $urandom, 16'($urandom));
  endtask

  task automatic wait_table_idle();
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_ch.valid         = 1'b1;
    cfg_ch.timeout_ticks = ticks;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    int pick;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_PACKET;
    in_ch.src_ip         = '0;
    in_ch.src_port       = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timeout_ticks = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: address/port extremes, known and new senders, full table
    send_item(CMD_PACKET, 32'h0000_0000, 16'h0000);
    send_item(CMD_PACKET, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_PACKET, 32'h0000_0000, 16'h0000);
    send_item(CMD_PACKET, 32'h0000_0000, 16'hFFFF);
    send_item(CMD_PACKET, 32'hFFFF_FFFF, 16'h0000);
    send_tick();
    for (int k = 0; k < 12; k++)
      send_item(CMD_PACKET, 32'h0A00_0000 + k, 16'(1000 + k));
    send_item(CMD_PACKET, 32'hC0A8_0101, 16'd5004);
    send_item(CMD_PACKET, 32'h0000_0000, 16'h0000);
    send_tick();
    wait_table_idle();
    // zero timeout: the next tick ages every member out
    write_timeout(16'h0000);
    send_tick();
    send_item(CMD_PACKET, 32'h7F00_0001, 16'd4000);
    wait_table_idle();

    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_ip[p]   = $urandom;
      pool_port[p] = 16'($urandom);
    end
    // same address on other ports, same port on other addresses
    pool_ip[1]   = pool_ip[0];
    pool_ip[2]   = pool_ip[0];
    pool_port[4] = pool_port[3];

    phase_timeout[0] = 16'hFFFF;
    phase_timeout[1] = 16'($urandom_range(1, 10));
    phase_timeout[2] = 16'd0;
    phase_timeout[3] = 16'd3;
    phase_timeout[4] = 16'($urandom_range(12, 30));

    for (int ph = 0; ph < 5; ph++) begin
      write_timeout(phase_timeout[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          send_tick();
        end else if (pick < 90) begin
          pick = $urandom_range(0, POOL_SIZE - 1);
          send_item(CMD_PACKET, pool_ip[pick], pool_port[pick]);
        end else begin
          send_item(CMD_PACKET, $urandom, 16'($urandom));
        end
      end
      wait_table_idle();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
